// ===== rtl/core/npmf_pkg.sv =====
package npmf_pkg;

	localparam int MAX_PATTERN = 8;
	localparam int MAX_LINE    = 4096;

	localparam int CHAR_W = 8;
	localparam int PAT_W  = 64;
	localparam int LEN_W  = 4;
	localparam int IDX_W  = 12;
	localparam int CNT_W  = 13;
	localparam int POS_W  = $clog2(MAX_LINE + 1);
	localparam int HIST_W = CHAR_W * (MAX_PATTERN - 1);
	localparam int BLK_W  = 3;
	localparam int CFG_IDX_W = 2;
	localparam int OUT_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_BYTES  = 2'd0,
		REG_PAT_LEN        = 2'd1,
		REG_MATCH_LIMIT    = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		KIND_MATCH   = 1'b0,
		KIND_SUMMARY = 1'b1
	} kind_t;

	// results caused by one input byte
	typedef struct packed {
		logic             has_match;
		logic             has_sum;
		logic [IDX_W-1:0] start_idx;
		logic [CNT_W-1:0] hit_count;
	} byte_result_t;

	typedef struct packed {
		logic [PAT_W-1:0] pattern_bytes;
		logic [LEN_W-1:0] pat_len;
		logic [CNT_W-1:0] match_limit;
	} npmf_cfg_t;

endpackage

// ===== rtl/core/npmf_scan.sv =====
module npmf_scan (
	input  logic                            clk,
	input  logic                            arst_n,
	input  npmf_pkg::npmf_cfg_t             cfg,
	input  logic                            advance,
	input  logic [npmf_pkg::CHAR_W-1:0]     char_value,
	input  logic                            line_end,
	output logic                            result_valid,
	output npmf_pkg::byte_result_t          result
);
	import npmf_pkg::*;

	logic [HIST_W-1:0] recent_q;
	logic [POS_W-1:0]  pos_q;
	logic [BLK_W-1:0]  blocked_q;
	logic [CNT_W-1:0]  found_q;

	logic [PAT_W-1:0]  window;
	logic [MAX_PATTERN:0] len_match;
	logic [LEN_W-1:0]  eff_len;
	logic              active;
	logic              long_enough;
	logic              hit;
	logic [CNT_W-1:0]  found_next;
	logic [POS_W-1:0]  start_pos;

	// newest byte in the low lane, older bytes above
	assign window = {recent_q, char_value};

	always_comb begin
		logic ok;
		len_match = '0;
		for (int l = 1; l <= MAX_PATTERN; l++) begin
			ok = 1'b1;
			for (int i = 0; i < MAX_PATTERN; i++) begin
				if (i < l) begin
					if (cfg.pattern_bytes[CHAR_W*i +: CHAR_W] !=
					    window[CHAR_W*(l-1-i) +: CHAR_W])
						ok = 1'b0;
				end
			end
			len_match[l] = ok;
		end
	end

	assign eff_len = (cfg.pat_len > LEN_W'(MAX_PATTERN)) ?
		LEN_W'(MAX_PATTERN) : cfg.pat_len;
	assign active = pos_q < POS_W'(MAX_LINE);
	assign long_enough = ({1'b0, pos_q} + (POS_W+1)'(1)) >= (POS_W+1)'(eff_len);

	assign hit = active && (blocked_q == '0) && (found_q < cfg.match_limit) &&
		(eff_len != '0) && long_enough && len_match[eff_len];

	assign found_next = hit ? found_q + CNT_W'(1) : found_q;
	assign start_pos  = pos_q + POS_W'(1) - POS_W'(eff_len);

	assign result_valid       = hit || line_end;
	assign result.has_match   = hit;
	assign result.has_sum     = line_end;
	assign result.start_idx   = start_pos[IDX_W-1:0];
	assign result.hit_count   = found_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recent_q  <= '0;
			pos_q     <= '0;
			blocked_q <= '0;
			found_q   <= '0;
		end else if (advance) begin
			if (line_end) begin
				recent_q  <= '0;
				pos_q     <= '0;
				blocked_q <= '0;
				found_q   <= '0;
			end else if (active) begin
				recent_q <= window[HIST_W-1:0];
				pos_q    <= pos_q + POS_W'(1);
				found_q  <= found_next;
				if (hit)
					blocked_q <= BLK_W'(eff_len - LEN_W'(1));
				else if (blocked_q != '0)
					blocked_q <= blocked_q - BLK_W'(1);
			end
		end
	end

endmodule

// ===== rtl/core/npmf_out_queue.sv =====
module npmf_out_queue (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_valid,
	input  npmf_pkg::byte_result_t            wr_result,
	output logic                              full,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [npmf_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // start_idx, hit_count
	output logic                              m_axis_tuser,  // kind
	output logic                              m_axis_tlast   // last
);
	import npmf_pkg::*;

	localparam int DEPTH = 2;

	byte_result_t entry_q [DEPTH];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;
	logic         phase_q;

	byte_result_t head;
	logic         show_match;
	logic         beat;
	logic         pop;
	logic         push;

	assign head       = entry_q[rd_ptr_q];
	assign show_match = head.has_match && !phase_q;
	assign full       = count_q == 2'(DEPTH);
	assign push       = wr_valid && !full;

	assign m_axis_tvalid = count_q != '0;
	assign m_axis_tuser  = show_match ? KIND_MATCH : KIND_SUMMARY;
	assign m_axis_tlast  = show_match ? !head.has_sum : 1'b1;
	assign m_axis_tdata  = {{(OUT_DATA_W-IDX_W-CNT_W){1'b0}}, head.hit_count,
		show_match ? head.start_idx : {IDX_W{1'b0}}};

	assign beat = m_axis_tvalid && m_axis_tready;
	assign pop  = beat && m_axis_tlast;

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= wr_result;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
			phase_q  <= 1'b0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
				phase_q  <= 1'b0;
			end else if (beat) begin
				phase_q <= 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/core/nonoverlapping_pattern_match_finder_core.sv =====
// Finds non-overlapping occurrences of a 1 to 8 byte pattern in a stream of line
// bytes. Each accepted byte is compared against the pattern over a window of itself
// and the previous seven bytes in the same cycle, so a new byte can be taken every
// clock while the queue is not full. A match word (tuser 0) carries the start
// position and running count; the last byte of a line (tlast in) also yields a
// summary word (tuser 1) with the line total, after any match word of that byte.
// Results pass through a two-entry queue of per-byte records; a byte that makes both
// a match and a summary is sent as two output words, so sustained rate is one byte
// per clock with the output ready unless lines end on a match. Bytes beyond position
// 4095 of a line are ignored. Write the configuration only while the block is idle.
module nonoverlapping_pattern_match_finder_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [npmf_pkg::CHAR_W-1:0]         s_axis_tdata,  // char_value
	input  logic                                s_axis_tlast,  // line_end
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [npmf_pkg::OUT_DATA_W-1:0]     m_axis_tdata,  // start_idx, hit_count
	output logic                                m_axis_tuser,  // kind
	output logic                                m_axis_tlast,  // last
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [npmf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [npmf_pkg::PAT_W-1:0]          cfg_data
);
	import npmf_pkg::*;

	npmf_cfg_t    cfg_q;
	logic         full;
	logic         accept;
	logic         result_valid;
	byte_result_t result;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !full;
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pattern_bytes  <= '0;
			cfg_q.pat_len        <= LEN_W'(1);
			cfg_q.match_limit    <= CNT_W'(MAX_LINE);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_PATTERN_BYTES:  cfg_q.pattern_bytes  <= cfg_data;
				REG_PAT_LEN:        cfg_q.pat_len        <= cfg_data[LEN_W-1:0];
				REG_MATCH_LIMIT:    cfg_q.match_limit    <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	npmf_scan u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.advance      (accept),
		.char_value   (s_axis_tdata),
		.line_end     (s_axis_tlast),
		.result_valid (result_valid),
		.result       (result)
	);

	npmf_out_queue u_out_queue (
		.clk           (clk),
		.arst_n        (arst_n),
		.wr_valid      (accept && result_valid),
		.wr_result     (result),
		.full          (full),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

// ===== tb/sv/tb_nonoverlapping_pattern_match_finder_core.sv =====
`timescale 1ns / 100ps

module tb_nonoverlapping_pattern_match_finder_core;
	import npmf_pkg::*;

	localparam int IDLE_LIMIT = 3000;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_ITEMS = 600;

	typedef struct {
		kind_t            kind;
		logic [IDX_W-1:0] idx;
		logic [CNT_W-1:0] cnt;
		logic             lst;
	} finder_word_t;

	class match_tracker;
		logic [PAT_W-1:0]  pat;
		logic [LEN_W-1:0]  plen;
		logic [CNT_W-1:0]  limit;
		logic [HIST_W-1:0] recent;
		int unsigned       line_pos;
		logic [BLK_W-1:0]  blocked;
		logic [CNT_W-1:0]  found;
		finder_word_t      pending_words[$];
		int                mismatches;

		function new();
			pat = '0;
			plen = LEN_W'(1);
			limit = CNT_W'(4096);
			mismatches = 0;
			clear_line();
		endfunction

		function void clear_line();
			recent = '0;
			line_pos = 0;
			blocked = '0;
			found = '0;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [PAT_W-1:0] v);
			case (idx)
				REG_PATTERN_BYTES: begin
					pat = v;
				end
				REG_PAT_LEN: begin
					plen = v[LEN_W-1:0];
				end
				REG_MATCH_LIMIT: begin
					limit = v[CNT_W-1:0];
				end
				default: begin
				end
			endcase
		endfunction

		// window of the current byte and the stored history against the pattern
		function bit window_hit(logic [CHAR_W-1:0] c, int unsigned len);
			logic [CHAR_W-1:0] want;
			logic [CHAR_W-1:0] got;
			int unsigned age;
			if (len == 0)
				return 0;
			if (line_pos + 1 < len)
				return 0;
			for (int i = 0; i < len; i++) begin
				want = pat[8*i +: 8];
				age = len - 1 - i;
				got = (age == 0) ? c : recent[8*(age-1) +: 8];
				if (want != got)
					return 0;
			end
			return 1;
		endfunction

		function void note_byte(logic [CHAR_W-1:0] c, logic endf);
			int unsigned len;
			finder_word_t w;
			if (line_pos < MAX_LINE) begin
				len = (plen > MAX_PATTERN) ? MAX_PATTERN : plen;
				if (blocked != 0) begin
					blocked = blocked - 1'b1;
				end else if (found < limit && window_hit(c, len)) begin
					found = found + 1'b1;
					blocked = BLK_W'(len - 1);
					w.kind = KIND_MATCH;
					w.idx = IDX_W'(line_pos + 1 - len);
					w.cnt = found;
					w.lst = !endf;
					pending_words.push_back(w);
				end
				recent = {recent[HIST_W-CHAR_W-1:0], c};
				line_pos++;
			end
			if (endf) begin
				w.kind = KIND_SUMMARY;
				w.idx = '0;
				w.cnt = found;
				w.lst = 1'b1;
				pending_words.push_back(w);
				clear_line();
			end
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			mismatches++;
		endtask

		task check_word(logic [OUT_DATA_W-1:0] data, logic user, logic lst);
			finder_word_t w;
			if (pending_words.size() == 0) begin
				report($sformatf("unexpected word tdata=%h tuser=%0d tlast=%0d",
					data, user, lst));
				return;
			end
			w = pending_words.pop_front();
			if (user !== w.kind)
				report($sformatf("kind %0d, want %0d", user, w.kind));
			if (data[IDX_W-1:0] !== w.idx)
				report($sformatf("start index %0d, want %0d", data[IDX_W-1:0], w.idx));
			if (data[IDX_W +: CNT_W] !== w.cnt)
				report($sformatf("hit count %0d, want %0d", data[IDX_W +: CNT_W], w.cnt));
			if (data[OUT_DATA_W-1:IDX_W+CNT_W] !== '0)
				report($sformatf("tdata pad bits not zero: %h", data));
			if (lst !== w.lst)
				report($sformatf("last %0d, want %0d", lst, w.lst));
		endtask
	endclass

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [CHAR_W-1:0]     s_axis_tdata = '0;
	logic                  s_axis_tlast = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tuser;
	logic                  m_axis_tlast;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [PAT_W-1:0]      cfg_data = '0;

	match_tracker tracker = new();
	int idle_cycles = 0;
	int items_sent = 0;
	bit tx_quiet = 0;
	logic [CHAR_W-1:0] line_buf[$];

	nonoverlapping_pattern_match_finder_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// handshakes are sampled mid-cycle, where every signal is settled
	always @(negedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				tracker.note_byte(s_axis_tdata, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready)
				tracker.check_word(m_axis_tdata, m_axis_tuser, m_axis_tlast);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb_nonoverlapping_pattern_match_finder_core: done, errors");
				$finish;
			end
		end
	end

	// result side: random stall before each word, with quiet stretches
	initial begin : rx_side
		int stall;
		bit ok;
		bit rx_quiet;
		rx_quiet = 0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 39) == 0)
				rx_quiet = !rx_quiet;
			stall = rx_quiet ? 0 : $urandom_range(0, 17);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do begin
				@(negedge clk);
				ok = m_axis_tvalid;
				@(posedge clk);
			end while (!ok);
		end
	end

	task automatic send_byte(logic [CHAR_W-1:0] c, logic endf);
		int gap;
		bit ok;
		gap = tx_quiet ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= c;
		s_axis_tlast <= endf;
		do begin
			@(negedge clk);
			ok = s_axis_tready;
			@(posedge clk);
		end while (!ok);
		items_sent++;
	endtask

	task automatic send_line();
		for (int i = 0; i < line_buf.size(); i++)
			send_byte(line_buf[i], i == line_buf.size() - 1);
	endtask

	// drop valid, wait for every expected word, then let the pipeline drain
	task automatic finish_phase();
		s_axis_tvalid <= 1'b0;
		while (tracker.pending_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_word(cfg_reg_t idx, logic [PAT_W-1:0] v);
		bit ok;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do begin
			@(negedge clk);
			ok = cfg_ready;
			@(posedge clk);
		end while (!ok);
		tracker.set_reg(idx, v);
	endtask

	task automatic set_config(logic [PAT_W-1:0] pat, int unsigned plen, int unsigned lim);
		cfg_word(REG_PATTERN_BYTES, pat);
		cfg_word(REG_PAT_LEN, PAT_W'(plen));
		cfg_word(REG_MATCH_LIMIT, PAT_W'(lim));
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		int unsigned plen;
		int unsigned eff;
		int unsigned lim;
		int unsigned target;
		int unsigned cut;
		int unsigned r;
		int phase_start;
		int rand_start;
		logic [PAT_W-1:0] pat;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: one zero byte pattern, zero bytes are ordinary
		line_buf = '{8'h00, 8'h41, 8'h00};
		send_line();
		finish_phase();

		// two byte pattern on a run of the same byte: no overlap
		set_config(64'h6161, 2, 4096);
		line_buf = '{8'h61, 8'h61, 8'h61, 8'h61, 8'h61};
		send_line();
		finish_phase();

		// full length pattern, match on the line's last byte
		set_config('1, 8, 4096);
		line_buf = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
		send_line();
		finish_phase();

		// length above the maximum acts as the maximum
		set_config('1, 15, 4096);
		line_buf = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
		send_line();
		finish_phase();

		// empty pattern never matches
		set_config(64'h6261, 0, 4096);
		line_buf = '{8'h61, 8'h62};
		send_line();
		finish_phase();

		// limit of zero, then limit of one
		set_config(64'h61, 1, 0);
		line_buf = '{8'h61, 8'h61};
		send_line();
		finish_phase();
		set_config(64'h61, 1, 1);
		line_buf = '{8'h61, 8'h61, 8'h61};
		send_line();
		finish_phase();

		rand_start = items_sent;
		while (items_sent < rand_start + RANDOM_ITEMS) begin
			r = $urandom_range(0, 19);
			if (r == 0)
				plen = 0;
			else if (r == 1)
				plen = $urandom_range(9, 15);
			else
				plen = $urandom_range(1, 8);
			if ($urandom_range(0, 3) == 0) begin
				pat = {$urandom, $urandom};
			end else begin
				for (int i = 0; i < 8; i++)
					pat[8*i +: 8] = 8'h61 + 8'($urandom_range(0, 2));
			end
			r = $urandom_range(0, 9);
			if (r == 0)
				lim = 0;
			else if (r <= 3)
				lim = $urandom_range(1, 4);
			else if (r == 4)
				lim = $urandom_range(0, 4096);
			else
				lim = 4096;
			set_config(pat, plen, lim);
			eff = (plen > MAX_PATTERN) ? MAX_PATTERN : plen;

			phase_start = items_sent;
			while (items_sent < phase_start + 70) begin
				tx_quiet = ($urandom_range(0, 4) == 0);
				target = $urandom_range(1, 32);
				line_buf.delete();
				while (line_buf.size() < target) begin
					r = $urandom_range(0, 9);
					if (r < 5 && eff > 0) begin
						// mostly whole pattern copies, sometimes a broken one
						cut = ($urandom_range(0, 4) == 0) ? $urandom_range(1, eff) : eff;
						for (int i = 0; i < cut; i++)
							line_buf.push_back(pat[8*i +: 8]);
					end else if (r < 8) begin
						line_buf.push_back(8'h61 + 8'($urandom_range(0, 2)));
					end else if (r == 8) begin
						line_buf.push_back(8'($urandom_range(1, 255)));
					end else begin
						line_buf.push_back($urandom_range(0, 1) ? 8'h00 : 8'hFF);
					end
				end
				send_line();
			end
			tx_quiet = 0;
			finish_phase();
		end

		repeat (20) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending_words.size() == 0)
			$display("tb_nonoverlapping_pattern_match_finder_core: done, clean");
		else
			$display("tb_nonoverlapping_pattern_match_finder_core: done, errors");
		$finish;
	end

endmodule
